// ===== sv/rdmac_pkg.sv =====
// Package for the retail DES MAC block: DES tables, bit permutations and the round function.
// Used by rdmac_front, rdmac_back and the top level; depends on nothing.
`default_nettype none
package rdmac_pkg;

	localparam int unsigned BlkW = 64;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW = 1;
	localparam logic [7:0] PadMark = 8'h80;
	localparam int unsigned PadShift = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_ONE = 1'b0,
		REG_KEY_TWO = 1'b1
	} reg_idx_t;

	// Operation for the back end, decided by the front end.
	typedef enum logic [1:0] {
		OP_CHAIN_FIRST = 2'd0,
		OP_CHAIN_NEXT  = 2'd1,
		OP_FINAL_ONLY  = 2'd2,
		OP_FINAL_PAD   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [63:0] data;
	} job_t;

	typedef logic [7:0] tab64_t [64];
	typedef logic [7:0] tab56_t [56];
	typedef logic [7:0] tab48_t [48];
	typedef logic [7:0] tab32_t [32];
	typedef logic [3:0] sbox_t [8][64];

	localparam tab64_t TIp = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
	localparam tab64_t TFp = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
	localparam tab48_t TE = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
	localparam tab32_t TP = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
	localparam tab56_t TPc1 = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
	localparam tab48_t TPc2 = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
	localparam logic [15:0] RotTwo = 16'b0011111101111110;
	localparam sbox_t TS = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Bit permutations; table entries count from the most significant bit, starting at one.
	function automatic logic [63:0] perm_ip(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = x[64-TIp[i]];
		return r;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = x[64-TFp[i]];
		return r;
	endfunction

	function automatic logic [55:0] perm_pc1(input logic [63:0] x);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = x[64-TPc1[i]];
		return r;
	endfunction

	function automatic logic [47:0] perm_pc2(input logic [55:0] x);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47-i] = x[56-TPc2[i]];
		return r;
	endfunction

	// Rotate both 28-bit key halves left by one or two.
	function automatic logic [55:0] rot_cd(input logic [55:0] cd, input logic two);
		logic [27:0] c;
		logic [27:0] d;
		c = cd[55:28];
		d = cd[27:0];
		if (two) begin
			c = {c[25:0], c[27:26]};
			d = {d[25:0], d[27:26]};
		end else begin
			c = {c[26:0], c[27]};
			d = {d[26:0], d[27]};
		end
		return {c, d};
	endfunction

	// All sixteen round keys of one DES key.
	typedef logic [47:0] subkeys_t [16];
	function automatic subkeys_t make_subkeys(input logic [63:0] key);
		subkeys_t sk;
		logic [55:0] cd;
		cd = perm_pc1(key);
		for (int i = 0; i < 16; i++) begin
			cd = rot_cd(cd, RotTwo[15-i]);
			sk[i] = perm_pc2(cd);
		end
		return sk;
	endfunction

	// Cipher function f of one round.
	function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
		logic [47:0] e;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0] six;
		for (int i = 0; i < 48; i++) e[47-i] = r[32-TE[i]];
		e = e ^ k;
		for (int j = 0; j < 8; j++) begin
			six = e[47-6*j -: 6];
			s[31-4*j -: 4] = TS[j][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32-TP[i]];
		return p;
	endfunction

	// One full single-DES pass, rounds unrolled.
	function automatic logic [63:0] des_block(input logic [63:0] blk, input subkeys_t sk,
		input logic decrypt);
		logic [63:0] x;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] t;
		x = perm_ip(blk);
		l = x[63:32];
		r = x[31:0];
		for (int i = 0; i < 16; i++) begin
			t = r;
			r = l ^ round_f(r, decrypt ? sk[15-i] : sk[i]);
			l = t;
		end
		return perm_fp({r, l});
	endfunction

endpackage
`default_nettype wire

// ===== sv/rdmac_front.sv =====
// Front end: accepts message blocks, tags each with its chaining operation, queues it.
// Depends on rdmac_pkg.
`default_nettype none
module rdmac_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [63:0]       data_block,
	input  wire logic              last_block,
	output logic                   job_valid,
	input  wire logic              job_ready,
	output rdmac_pkg::job_t        job
);
	import rdmac_pkg::*;

	job_t              mem_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QPtrW:0]    count_q;
	logic              seen_q;
	logic              push;
	logic              pop;
	op_t               op_new;

	assign in_ready  = (count_q != (QPtrW+1)'(QDepth));
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;
	assign job_valid = (count_q != '0);
	assign job       = mem_q[rd_ptr_q];

	// Classify the request by message position.
	always_comb begin
		if (!last_block) op_new = seen_q ? OP_CHAIN_NEXT : OP_CHAIN_FIRST;
		else op_new = seen_q ? OP_FINAL_PAD : OP_FINAL_ONLY;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= '{op: op_new, data: data_block};
	end

	// Queue pointers and the message-position flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			seen_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				seen_q   <= !last_block;
			end
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== sv/rdmac_back.sv =====
// Back end: DES chaining and the final triple-DES step, with the result register.
// Depends on rdmac_pkg.
`default_nettype none
module rdmac_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [63:0]  key_one,
	input  wire logic [63:0]  key_two,
	input  wire logic         job_valid,
	output logic              job_ready,
	input  rdmac_pkg::job_t   job,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [63:0]       mac_value
);
	import rdmac_pkg::*;

	logic [63:0] icv_q;
	logic [63:0] chain_q;
	logic        busy_q;
	logic [63:0] mid_s1;
	logic [63:0] mac_q;
	logic        out_valid_q;
	logic [63:0] cv;
	logic [63:0] des1;
	logic [63:0] des3;
	logic        is_final;
	logic        take;
	subkeys_t    sk1;
	subkeys_t    sk2;

	assign sk1 = make_subkeys(key_one);
	assign sk2 = make_subkeys(key_two);

	// Chaining value by operation.
	always_comb begin
		case (job.op)
			OP_CHAIN_FIRST, OP_FINAL_ONLY: cv = icv_q;
			OP_FINAL_PAD: cv = chain_q ^ (64'(PadMark) << PadShift);
			default: cv = chain_q;
		endcase
	end

	assign is_final  = job.op inside {OP_FINAL_ONLY, OP_FINAL_PAD};
	// Every block waits for an idle second stage; a final block also waits for the output slot.
	assign job_ready = !busy_q && (!is_final || !out_valid_q || out_ready);
	assign take      = job_valid && job_ready;
	assign des1      = des_block(job.data ^ cv, sk1, 1'b0);
	// Second stage: decrypt under key two, encrypt under key one.
	assign des3      = des_block(des_block(mid_s1, sk2, 1'b1), sk1, 1'b0);

	always_ff @(posedge clk) begin
		if (take) mid_s1 <= des1;
		if (busy_q) mac_q <= des3;
	end

	// Chaining state and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icv_q       <= '0;
			chain_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && !is_final) chain_q <= des1;
			if (busy_q) begin
				icv_q   <= des3;
				chain_q <= des3;
			end
			busy_q <= take && is_final;
			if (busy_q) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign mac_value = mac_q;
endmodule
`default_nettype wire

// ===== sv/retail_des_mac_chained_icv.sv =====
// Top level of the retail DES MAC with chained ICV.
// Depends on rdmac_pkg, rdmac_front and rdmac_back.
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | data_block, last_block
//   out     | output    | out_valid / out_ready| mac_value
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
// A non-final block passes through the single-DES stage; one may follow each cycle
// while the second stage is idle. A final block runs single DES, then decrypt-encrypt,
// before the next enters. A two-entry queue parts input from the DES stage; a result
// register holds the MAC while out_ready is low. Reset clears keys and chaining state.
`default_nettype none
module retail_des_mac_chained_icv (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [63:0]             data_block,
	input  wire logic                    last_block,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [63:0]                  mac_value,
	input  wire logic                    cfg_we,
	input  wire logic [rdmac_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [63:0]             cfg_data
);
	import rdmac_pkg::*;

	logic [63:0] key_one_q;
	logic [63:0] key_two_q;
	logic        job_valid;
	logic        job_ready;
	job_t        job;

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_one_q <= '0;
			key_two_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_ONE: key_one_q <= cfg_data;
				REG_KEY_TWO: key_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rdmac_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_block, .last_block,
		.job_valid, .job_ready, .job
	);

	rdmac_back u_back (
		.clk, .arst_n, .key_one(key_one_q), .key_two(key_two_q),
		.job_valid, .job_ready, .job, .out_valid, .out_ready, .mac_value
	);
endmodule
`default_nettype wire

// ===== sv/rdmac_checker.sv =====
// Port-level checker for the retail DES MAC block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rdmac_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] mac_value
);
	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mac_value))
		else $error("result changed while stalled");

	// No result is offered while reset is applied.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

	// The in_valid, in_ready and out_valid handshake signals are always known out of reset.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid}))
		else $error("handshake signal unknown");

	// An offered result carries a known value.
	a_mac_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(mac_value))
		else $error("result value unknown");
endmodule

bind retail_des_mac_chained_icv rdmac_checker u_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .mac_value
);
`default_nettype wire
